[rtl/core/assert_macros.svh]
// Assertion macros shared by the checker files of this block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_COMB(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/twcs_pkg.sv]
// Shared constants and types of the textured wall column shader.
// No dependencies; used by the top level and the port checker.
package twcs_pkg;

    // Texture geometry defaults and fixed texture count
    localparam int TEX_WIDTH_DEF  = 64;
    localparam int TEX_HEIGHT_DEF = 64;
    localparam int NUM_TEXTURES   = 4;
    localparam int TEX_SEL_W      = 2;

    // Field widths
    localparam int HEIGHT_W  = 12;
    localparam int COLOR_W   = 32;
    localparam int WALL_W    = 24;
    localparam int HIT_W     = 24;
    localparam int FRAC_W    = 16;
    localparam int LOAD_RC_W = 6;

    // Port widths
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Input tdata field positions
    localparam int LD_TEX_LSB  = 0;
    localparam int LD_ROW_LSB  = 2;
    localparam int LD_COL_LSB  = 8;
    localparam int LD_VAL_LSB  = 14;
    localparam int PIX_ROW_LSB = 46;
    localparam int WALL_LSB    = 58;
    localparam int HIT_X_LSB   = 82;
    localparam int HIT_Y_LSB   = 106;
    localparam int SIDE_BIT    = 130;
    localparam int DIR_BIT     = 131;

    // Request kinds carried in s_tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CEILING_COLOR = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR_COLOR   = 2'd2;

    localparam logic [HEIGHT_W-1:0] SCREEN_HEIGHT_RST = 12'd480;

    // Texture ids by wall orientation
    localparam logic [TEX_SEL_W-1:0] TEX_Y_POS = 2'd0;
    localparam logic [TEX_SEL_W-1:0] TEX_Y_NEG = 2'd1;
    localparam logic [TEX_SEL_W-1:0] TEX_X_NEG = 2'd2;
    localparam logic [TEX_SEL_W-1:0] TEX_X_POS = 2'd3;

    // Pixel region reported in m_tuser
    typedef enum logic [OUT_TUSER_W-1:0] {
        REGION_CEILING = 2'd0,
        REGION_WALL    = 2'd1,
        REGION_FLOOR   = 2'd2
    } region_t;

endpackage

[rtl/core/twcs_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a sideband vector alongside; no package dependency.
module twcs_div_pipe #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 25,
    parameter int QUOT_W     = 7,
    parameter int SIDE_W     = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  out_valid,
    output logic [QUOT_W-1:0]     quot,
    output logic [SIDE_W-1:0]     side_out
);

    logic [QUOT_W-1:0]     valid_reg;
    logic [QUOT_W-1:0]     valid_next;
    logic [DIVIDEND_W-1:0] rem_reg   [QUOT_W];
    logic [DIVIDEND_W-1:0] rem_next  [QUOT_W];
    logic [DIVISOR_W-1:0]  dvs_reg   [QUOT_W];
    logic [DIVISOR_W-1:0]  dvs_next  [QUOT_W];
    logic [QUOT_W-1:0]     quot_reg  [QUOT_W];
    logic [QUOT_W-1:0]     quot_next [QUOT_W];
    logic [SIDE_W-1:0]     side_reg  [QUOT_W];
    logic [SIDE_W-1:0]     side_next [QUOT_W];

    // Stage inputs: port for stage 0, previous stage otherwise
    logic [DIVIDEND_W-1:0] rem_in  [QUOT_W];
    logic [DIVISOR_W-1:0]  dvs_in  [QUOT_W];
    logic [QUOT_W-1:0]     quot_in [QUOT_W];
    logic [DIVIDEND_W-1:0] trial   [QUOT_W];
    logic [QUOT_W-1:0]     ge;

    always_comb
    begin
        rem_in[0]    = dividend;
        dvs_in[0]    = divisor;
        quot_in[0]   = '0;
        side_next[0] = side_in;
        for (int k = 1; k < QUOT_W; k++)
        begin
            rem_in[k]    = rem_reg[k-1];
            dvs_in[k]    = dvs_reg[k-1];
            quot_in[k]   = quot_reg[k-1];
            side_next[k] = side_reg[k-1];
        end
    end

    // Stage k decides quotient bit QUOT_W-1-k
    always_comb
    begin
        for (int k = 0; k < QUOT_W; k++)
        begin
            trial[k]     = DIVIDEND_W'(dvs_in[k]) << (QUOT_W - 1 - k);
            ge[k]        = rem_in[k] >= trial[k];
            rem_next[k]  = ge[k] ? (rem_in[k] - trial[k]) : rem_in[k];
            dvs_next[k]  = dvs_in[k];
            quot_next[k] = quot_in[k] | (QUOT_W'(ge[k]) << (QUOT_W - 1 - k));
        end
    end

    assign valid_next = {valid_reg[QUOT_W-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            quot_reg <= quot_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg[QUOT_W-1];
    assign quot      = quot_reg[QUOT_W-1];
    assign side_out  = side_reg[QUOT_W-1];

endmodule

[rtl/core/twcs_tex_mem.sv]
// Texel store: one port, write or registered read per enabled cycle.
// No package dependency; contents are undefined until written.
module twcs_tex_mem #(
    parameter int DEPTH  = 16384,
    parameter int AW     = 14,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [AW-1:0]     addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] texel_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Read data holds while the pipeline is stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                texel_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= texel_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/textured_wall_column_shader_top.sv]
// Top level of the textured wall column shader: region decision, texel
// addressing and fetch. Uses twcs_pkg, twcs_div_pipe and twcs_tex_mem.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata load/pixel fields, s_tuser req_type
//  m_*     | out | m_tvalid/m_tready  | m_tdata color, m_tuser region
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// One item per cycle unless the output stalls. The texel row divider
// resolves one quotient bit per stage.
// Load items pass the same stages and write the store at the read stage,
// so item order is kept; they give no result. No clearing pass after reset.
// While the output register is full and not taken, every stage holds.
module textured_wall_column_shader_top #(
    parameter int TEX_WIDTH  = twcs_pkg::TEX_WIDTH_DEF,
    parameter int TEX_HEIGHT = twcs_pkg::TEX_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // load_texture, load_row, load_col, load_value, pixel_row, wall_height,
    // hit_x, hit_y, side, dir_positive (lowest bit up), zero padded
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [twcs_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tuser,   // req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [twcs_pkg::COLOR_W-1:0]        m_tdata,   // color
    output logic [twcs_pkg::OUT_TUSER_W-1:0]    m_tuser,   // region
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [twcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [twcs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int HW      = twcs_pkg::HEIGHT_W;
    localparam int CLR_W   = twcs_pkg::COLOR_W;
    localparam int WH_W    = twcs_pkg::WALL_W;
    localparam int FR_W    = twcs_pkg::FRAC_W;
    localparam int TS_W    = twcs_pkg::TEX_SEL_W;
    localparam int LRC_W   = twcs_pkg::LOAD_RC_W;
    localparam int RW      = $clog2(TEX_HEIGHT);
    localparam int CW      = $clog2(TEX_WIDTH);
    localparam int QW      = $clog2(TEX_HEIGHT + 1);
    localparam int Y2_W    = HW + 9;
    localparam int MID_W   = HW + 8;
    localparam int NUM_W   = WH_W + 1;
    localparam int DIV_W   = NUM_W + QW;
    localparam int FRM_W   = FR_W + 1;
    localparam int CPROD_W = FRM_W + $clog2(TEX_WIDTH + 1);
    localparam int CQ_W    = CPROD_W - FR_W;
    localparam int DEPTH   = twcs_pkg::NUM_TEXTURES * TEX_HEIGHT * TEX_WIDTH;
    localparam int AW      = $clog2(DEPTH);
    localparam int LIN_W   = $clog2(twcs_pkg::NUM_TEXTURES * TEX_HEIGHT);
    localparam int SIDE_W  = 1 + 2 + TS_W + RW + CW + 1 + 1 + CLR_W;

    localparam logic [FRM_W-1:0] FRAC_ONE = FRM_W'(1) << FR_W;

    // ------------------------------------------------------------------
    // Configuration registers
    logic [HW-1:0]    screen_height_reg;
    logic [CLR_W-1:0] ceiling_color_reg;
    logic [CLR_W-1:0] floor_color_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_height_reg <= twcs_pkg::SCREEN_HEIGHT_RST;
            ceiling_color_reg <= '0;
            floor_color_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                twcs_pkg::CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[HW-1:0];
                twcs_pkg::CFG_CEILING_COLOR: ceiling_color_reg <= cfg_data;
                twcs_pkg::CFG_FLOOR_COLOR:   floor_color_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global advance: every stage moves when the output can take an item
    logic out_valid_reg;
    logic en;
    logic accept;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    // Input field unpacking
    logic [TS_W-1:0]  in_ld_tex;
    logic [LRC_W-1:0] in_ld_row;
    logic [LRC_W-1:0] in_ld_col;
    logic [CLR_W-1:0] in_ld_val;
    logic [HW-1:0]    in_pix_row;
    logic [WH_W-1:0]  in_wall;
    logic [FR_W-1:0]  in_frac_x;
    logic [FR_W-1:0]  in_frac_y;
    logic             in_side;
    logic             in_dir_pos;

    assign in_ld_tex  = s_tdata[twcs_pkg::LD_TEX_LSB +: TS_W];
    assign in_ld_row  = s_tdata[twcs_pkg::LD_ROW_LSB +: LRC_W];
    assign in_ld_col  = s_tdata[twcs_pkg::LD_COL_LSB +: LRC_W];
    assign in_ld_val  = s_tdata[twcs_pkg::LD_VAL_LSB +: CLR_W];
    assign in_pix_row = s_tdata[twcs_pkg::PIX_ROW_LSB +: HW];
    assign in_wall    = s_tdata[twcs_pkg::WALL_LSB +: WH_W];
    assign in_frac_x  = s_tdata[twcs_pkg::HIT_X_LSB +: FR_W];
    assign in_frac_y  = s_tdata[twcs_pkg::HIT_Y_LSB +: FR_W];
    assign in_side    = s_tdata[twcs_pkg::SIDE_BIT];
    assign in_dir_pos = s_tdata[twcs_pkg::DIR_BIT];

    // ------------------------------------------------------------------
    // Stage 1: span compares, texture choice, column fraction
    logic [Y2_W-1:0]  y2;
    logic [MID_W-1:0] mid;
    logic [NUM_W-1:0] top_sum;
    logic [NUM_W-1:0] bot_lim;
    logic             is_ceil;
    logic             is_floor;
    logic [FR_W-1:0]  frac_raw;

    logic                  s1_valid_reg;
    logic                  s1_is_pixel_reg, s1_is_pixel_next;
    twcs_pkg::region_t     s1_region_reg, s1_region_next;
    logic [TS_W-1:0]       s1_tex_reg, s1_tex_next;
    logic [NUM_W-1:0]      s1_num_reg, s1_num_next;
    logic [WH_W-1:0]       s1_wh_reg;
    logic                  s1_wh_zero_reg, s1_wh_zero_next;
    logic [FRM_W-1:0]      s1_fracm_reg, s1_fracm_next;
    logic [RW-1:0]         s1_ld_row_reg, s1_ld_row_next;
    logic [CW-1:0]         s1_ld_col_reg, s1_ld_col_next;
    logic                  s1_ld_ok_reg, s1_ld_ok_next;
    logic [CLR_W-1:0]      s1_data_reg, s1_data_next;

    always_comb
    begin
        y2       = {in_pix_row, 9'd0};
        mid      = {screen_height_reg, 8'd0};
        top_sum  = NUM_W'(y2) + NUM_W'(in_wall);
        bot_lim  = NUM_W'(mid) + NUM_W'(in_wall);
        is_ceil  = top_sum < NUM_W'(mid);
        is_floor = NUM_W'(y2) > bot_lim;

        s1_is_pixel_next = (s_tuser == twcs_pkg::REQ_PIXEL);
        s1_num_next      = top_sum - NUM_W'(mid);
        s1_wh_zero_next  = (in_wall == '0);

        if (is_ceil)
            s1_region_next = twcs_pkg::REGION_CEILING;
        else if (is_floor)
            s1_region_next = twcs_pkg::REGION_FLOOR;
        else
            s1_region_next = twcs_pkg::REGION_WALL;

        // Texture from side and step sign; loads name it directly
        if (!s1_is_pixel_next)
            s1_tex_next = in_ld_tex;
        else if (!in_side)
            s1_tex_next = in_dir_pos ? twcs_pkg::TEX_Y_POS : twcs_pkg::TEX_Y_NEG;
        else
            s1_tex_next = in_dir_pos ? twcs_pkg::TEX_X_POS : twcs_pkg::TEX_X_NEG;

        // Column fraction, mirrored for the negative-facing textures
        frac_raw = in_side ? in_frac_y : in_frac_x;
        if (s1_tex_next == twcs_pkg::TEX_Y_NEG || s1_tex_next == twcs_pkg::TEX_X_NEG)
            s1_fracm_next = FRAC_ONE - FRM_W'(frac_raw);
        else
            s1_fracm_next = FRM_W'(frac_raw);

        // Load address check; out-of-range loads are dropped
        s1_ld_ok_next  = (int'(in_ld_row) < TEX_HEIGHT) && (int'(in_ld_col) < TEX_WIDTH);
        s1_ld_row_next = RW'(in_ld_row);
        s1_ld_col_next = CW'(in_ld_col);

        if (!s1_is_pixel_next)
            s1_data_next = in_ld_val;
        else if (is_ceil)
            s1_data_next = ceiling_color_reg;
        else
            s1_data_next = floor_color_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_is_pixel_reg <= s1_is_pixel_next;
            s1_region_reg   <= s1_region_next;
            s1_tex_reg      <= s1_tex_next;
            s1_num_reg      <= s1_num_next;
            s1_wh_reg       <= in_wall;
            s1_wh_zero_reg  <= s1_wh_zero_next;
            s1_fracm_reg    <= s1_fracm_next;
            s1_ld_row_reg   <= s1_ld_row_next;
            s1_ld_col_reg   <= s1_ld_col_next;
            s1_ld_ok_reg    <= s1_ld_ok_next;
            s1_data_reg     <= s1_data_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale numerator by texture height, texel column
    logic [CPROD_W-1:0] col_prod;
    logic [CQ_W-1:0]    col_q;
    logic [CW-1:0]      col_pix;

    logic               s2_valid_reg;
    logic [DIV_W-1:0]   s2_dividend_reg, s2_dividend_next;
    logic [NUM_W-1:0]   s2_divisor_reg, s2_divisor_next;
    logic [SIDE_W-1:0]  s2_side_reg, s2_side_next;

    always_comb
    begin
        s2_dividend_next = DIV_W'(s1_num_reg) * DIV_W'(TEX_HEIGHT);
        s2_divisor_next  = {s1_wh_reg, 1'b0};
        col_prod         = CPROD_W'(s1_fracm_reg) * CPROD_W'(TEX_WIDTH);
        col_q            = col_prod[CPROD_W-1:FR_W];
        col_pix          = (col_q > CQ_W'(TEX_WIDTH - 1)) ? CW'(TEX_WIDTH - 1) : CW'(col_q);
        s2_side_next     = {s1_is_pixel_reg, s1_region_reg, s1_tex_reg, s1_ld_row_reg,
                            s1_is_pixel_reg ? col_pix : s1_ld_col_reg,
                            s1_ld_ok_reg, s1_wh_zero_reg, s1_data_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_dividend_reg <= s2_dividend_next;
            s2_divisor_reg  <= s2_divisor_next;
            s2_side_reg     <= s2_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Texel row divider: (num * TEX_HEIGHT) / (2 * wall_height)
    logic              dv_valid;
    logic [QW-1:0]     dv_quot;
    logic [SIDE_W-1:0] dv_side;

    twcs_div_pipe #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (NUM_W),
        .QUOT_W     (QW),
        .SIDE_W     (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .dividend  (s2_dividend_reg),
        .divisor   (s2_divisor_reg),
        .side_in   (s2_side_reg),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .side_out  (dv_side)
    );

    logic             dv_is_pixel;
    logic [1:0]       dv_region;
    logic [TS_W-1:0]  dv_tex;
    logic [RW-1:0]    dv_ld_row;
    logic [CW-1:0]    dv_col;
    logic             dv_ld_ok;
    logic             dv_wh_zero;
    logic [CLR_W-1:0] dv_data;

    assign {dv_is_pixel, dv_region, dv_tex, dv_ld_row, dv_col,
            dv_ld_ok, dv_wh_zero, dv_data} = dv_side;

    // ------------------------------------------------------------------
    // Stage A: clamp row, texture-row index
    logic [RW-1:0]      row_a;

    logic               sa_valid_reg;
    logic               sa_is_pixel_reg;
    twcs_pkg::region_t  sa_region_reg;
    logic [LIN_W-1:0]   sa_lin_reg, sa_lin_next;
    logic [CW-1:0]      sa_col_reg;
    logic               sa_ld_ok_reg;
    logic [CLR_W-1:0]   sa_data_reg;

    always_comb
    begin
        if (!dv_is_pixel)
            row_a = dv_ld_row;
        else if (dv_wh_zero)
            row_a = '0;
        else if (dv_quot > QW'(TEX_HEIGHT - 1))
            row_a = RW'(TEX_HEIGHT - 1);
        else
            row_a = RW'(dv_quot);
        sa_lin_next = LIN_W'(dv_tex) * LIN_W'(TEX_HEIGHT) + LIN_W'(row_a);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sa_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_is_pixel_reg <= dv_is_pixel;
            sa_region_reg   <= twcs_pkg::region_t'(dv_region);
            sa_lin_reg      <= sa_lin_next;
            sa_col_reg      <= dv_col;
            sa_ld_ok_reg    <= dv_ld_ok;
            sa_data_reg     <= dv_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: linear texel address
    logic               sb_valid_reg;
    logic               sb_is_pixel_reg;
    twcs_pkg::region_t  sb_region_reg;
    logic [AW-1:0]      sb_addr_reg, sb_addr_next;
    logic               sb_we_reg;
    logic [CLR_W-1:0]   sb_data_reg;

    assign sb_addr_next = AW'(sa_lin_reg) * AW'(TEX_WIDTH) + AW'(sa_col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sb_valid_reg <= sa_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_is_pixel_reg <= sa_is_pixel_reg;
            sb_region_reg   <= sa_region_reg;
            sb_addr_reg     <= sb_addr_next;
            sb_we_reg       <= !sa_is_pixel_reg && sa_ld_ok_reg;
            sb_data_reg     <= sa_data_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: texel store access (load writes, pixel reads)
    logic [CLR_W-1:0] texel;

    twcs_tex_mem #(
        .DEPTH  (DEPTH),
        .AW     (AW),
        .DATA_W (CLR_W)
    ) u_tex_mem (
        .clk   (clk),
        .en    (en),
        .we    (sb_valid_reg && sb_we_reg),
        .addr  (sb_addr_reg),
        .wdata (sb_data_reg),
        .rdata (texel)
    );

    logic               sc_valid_reg;
    logic               sc_is_pixel_reg;
    twcs_pkg::region_t  sc_region_reg;
    logic [CLR_W-1:0]   sc_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sc_valid_reg <= sb_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_is_pixel_reg <= sb_is_pixel_reg;
            sc_region_reg   <= sb_region_reg;
            sc_data_reg     <= sb_data_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: only pixel items produce a result
    logic [CLR_W-1:0]   out_color_reg, out_color_next;
    twcs_pkg::region_t  out_region_reg;

    assign out_color_next = (sc_region_reg == twcs_pkg::REGION_WALL) ? texel : sc_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sc_valid_reg && sc_is_pixel_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_color_reg  <= out_color_next;
            out_region_reg <= sc_region_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_color_reg;
    assign m_tuser  = out_region_reg;

endmodule

[rtl/core/twcs_checker.sv]
// Port-level checker for the textured wall column shader, bound to the top.
// Depends on twcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module twcs_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [twcs_pkg::COLOR_W-1:0]        m_tdata,
    input logic [twcs_pkg::OUT_TUSER_W-1:0]    m_tuser
);

    logic out_stall;
    logic region_ok;

    assign out_stall = m_tvalid && !m_tready;
    assign region_ok = (m_tuser == twcs_pkg::REGION_CEILING) ||
                       (m_tuser == twcs_pkg::REGION_WALL) ||
                       (m_tuser == twcs_pkg::REGION_FLOOR);

    // A stalled result keeps its color and region
    `ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable({m_tdata, m_tuser}), "stalled result moved")

    // Input side is ready exactly when the output register can advance
    `ASSERT_COMB(a_ready_tracks_out, s_tready == (!m_tvalid || m_tready), "ready out of step")

    // Every result reports a defined region
    `ASSERT_IMPLY(a_region_legal, m_tvalid, region_ok, "undefined region code")

endmodule

bind textured_wall_column_shader_top twcs_checker u_twcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);
